/* rtl/spms_pkg.sv */
package spms_pkg;

	// Operation codes carried on the opcode field.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	// Width of one stored value and the value returned by a pop of an empty stack.
	localparam int unsigned DATA_W = 32;
	localparam logic [DATA_W-1:0] UNDERFLOW_VALUE = 32'h7FFF_FFFF;

	// Per-cycle commands to the slot memory.
	typedef struct packed {
		logic wr_data_en;
		logic wr_link_en;
		logic rd_en;
	} spms_mem_ctl_t;

endpackage

/* rtl/shared_pool_multi_stack_core.sv */
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  opcode, stack_id, push_value
// output    out        out_valid / out_stall pop_value, status
//
// One push or pop is accepted per cycle while in_stall is low; it passes the input register
// and then the output register, where its result is valid.
// The rate is set by the top-of-stack and free-list caches, which let every item finish
// in one pass while the slot memory read for the next one lands in the following cycle.
// Reset empties all stacks at once; a high-water count stands in for the initial link chain.
// A stalled result holds in the output register; the input register then fills and stalls.
module shared_pool_multi_stack_core import spms_pkg::*; #(
	parameter int unsigned POOL_SLOTS = 16,
	parameter int unsigned STACKS     = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [1:0]               stack_id,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] pop_value,
	output logic [1:0]               status
);

	localparam int unsigned LW = $clog2(POOL_SLOTS + 1);
	localparam int unsigned AW = $clog2(POOL_SLOTS);
	localparam int unsigned SW = (STACKS > 1) ? $clog2(STACKS) : 1;
	localparam logic [LW-1:0] NULL_SLOT = LW'(POOL_SLOTS);
	localparam logic [LW-1:0] LAST_SLOT = LW'(POOL_SLOTS - 1);

	// Input register.
	logic              valid_s1;
	logic              opcode_s1;
	logic [1:0]        stack_id_s1;
	logic [DATA_W-1:0] push_value_s1;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] pop_value_q;
	logic [1:0]        status_q;

	// Free list head, its successor and the high-water count of slots ever used.
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] free_next_q;
	logic          fn_pend_q;
	logic [LW-1:0] hw_q;

	// Per-stack top slot with a copy of its link and value.
	logic [LW-1:0]     top_q      [STACKS];
	logic [LW-1:0]     top_link_q [STACKS];
	logic [DATA_W-1:0] top_data_q [STACKS];
	logic              st_pend_q;
	logic [SW-1:0]     st_pend_id_q;

	// Side data of the last memory read.
	logic          rd_fresh_q;
	logic [LW-1:0] rd_calc_q;

	// Memory interface.
	spms_mem_ctl_t     mem_ctl;
	logic [AW-1:0]     wr_addr;
	logic [LW-1:0]     wr_link;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic [LW-1:0]     rd_link;

	// Item decode.
	logic              advance;
	logic              fire;
	logic              accept;
	logic              sid_ok;
	logic [SW-1:0]     idx;
	logic [LW-1:0]     cur_top;
	logic [LW-1:0]     cur_link;
	logic [DATA_W-1:0] cur_data;
	logic              push_ok;
	logic              pop_ok;
	logic [LW-1:0]     fn_eff;
	logic [LW-1:0]     hw_next;
	logic              fn_touched;
	logic [LW-1:0]     tl_eff [STACKS];
	logic [DATA_W-1:0] td_eff [STACKS];

	// Handshake control.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1     <= opcode;
			stack_id_s1   <= stack_id;
			push_value_s1 <= push_value;
		end
	end

	// Resolve values whose memory read landed this cycle.
	assign fn_eff = fn_pend_q ? (rd_fresh_q ? rd_calc_q : rd_link) : free_next_q;

	always_comb begin
		for (int i = 0; i < STACKS; i++) begin
			if (st_pend_q && st_pend_id_q == SW'(i)) begin
				tl_eff[i] = rd_link;
				td_eff[i] = rd_data;
			end else begin
				tl_eff[i] = top_link_q[i];
				td_eff[i] = top_data_q[i];
			end
		end
	end

	// Decode of the item in the input register.
	assign sid_ok   = 32'(stack_id_s1) < STACKS;
	assign idx      = SW'(stack_id_s1);
	assign cur_top  = top_q[idx];
	assign cur_link = tl_eff[idx];
	assign cur_data = td_eff[idx];
	assign push_ok  = (opcode_s1 == OP_PUSH) && sid_ok && (free_head_q < NULL_SLOT);
	assign pop_ok   = (opcode_s1 == OP_POP) && sid_ok && (cur_top < NULL_SLOT);

	// Slots at or above the high-water count have never been linked; their link is computed, not read.
	assign hw_next    = (push_ok && free_head_q == hw_q) ? hw_q + LW'(1) : hw_q;
	assign fn_touched = fn_eff < hw_next;

	// Memory commands.
	always_comb begin
		mem_ctl = '0;
		wr_addr = free_head_q[AW-1:0];
		wr_link = cur_top;
		rd_addr = fn_eff[AW-1:0];
		if (fire && push_ok) begin
			mem_ctl.wr_data_en = 1'b1;
			mem_ctl.wr_link_en = 1'b1;
			mem_ctl.rd_en      = fn_touched;
		end else if (fire && pop_ok) begin
			wr_addr            = cur_top[AW-1:0];
			wr_link            = free_head_q;
			rd_addr            = cur_link[AW-1:0];
			mem_ctl.wr_link_en = 1'b1;
			mem_ctl.rd_en      = cur_link < NULL_SLOT;
		end
	end

	spms_slot_mem #(
		.SLOTS  (POOL_SLOTS),
		.LINK_W (LW)
	) u_slot_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (push_value_s1),
		.wr_link (wr_link),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rd_link (rd_link)
	);

	// Free list state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			free_next_q <= LW'(1);
			fn_pend_q   <= 1'b0;
			hw_q        <= '0;
			rd_fresh_q  <= 1'b0;
			rd_calc_q   <= NULL_SLOT;
		end else begin
			hw_q <= hw_next;
			if (fire && push_ok) begin
				free_head_q <= fn_eff;
				free_next_q <= fn_eff;
				fn_pend_q   <= 1'b1;
				rd_fresh_q  <= !fn_touched;
				rd_calc_q   <= (fn_eff >= LAST_SLOT) ? NULL_SLOT : fn_eff + LW'(1);
			end else if (fire && pop_ok) begin
				free_head_q <= cur_top;
				free_next_q <= free_head_q;
				fn_pend_q   <= 1'b0;
				rd_fresh_q  <= 1'b0;
			end else begin
				free_next_q <= fn_eff;
				fn_pend_q   <= 1'b0;
			end
		end
	end

	// Stack tops and pending read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACKS; i++) begin
				top_q[i] <= NULL_SLOT;
			end
			st_pend_q    <= 1'b0;
			st_pend_id_q <= '0;
		end else if (fire && push_ok) begin
			top_q[idx] <= free_head_q;
			st_pend_q  <= 1'b0;
		end else if (fire && pop_ok) begin
			top_q[idx]   <= (cur_link > NULL_SLOT) ? NULL_SLOT : cur_link;
			st_pend_q    <= 1'b1;
			st_pend_id_q <= idx;
		end else begin
			st_pend_q <= 1'b0;
		end
	end

	// Cached link and value of each top slot.
	always_ff @(posedge clk) begin
		for (int i = 0; i < STACKS; i++) begin
			if (fire && push_ok && idx == SW'(i)) begin
				top_link_q[i] <= cur_top;
				top_data_q[i] <= push_value_s1;
			end else begin
				top_link_q[i] <= tl_eff[i];
				top_data_q[i] <= td_eff[i];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			priority if (opcode_s1 == OP_PUSH) begin
				pop_value_q <= '0;
				status_q    <= push_ok ? ST_OK : ST_OVERFLOW;
			end else if (pop_ok) begin
				pop_value_q <= cur_data;
				status_q    <= ST_OK;
			end else begin
				pop_value_q <= UNDERFLOW_VALUE;
				status_q    <= ST_UNDERFLOW;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;

	// The memory is never read at the slot being written in the same cycle.
	a_rd_wr_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.rd_en && mem_ctl.wr_link_en) |-> (rd_addr != wr_addr))
		else $error("slot memory read and write collide");

	// The high-water count never passes the pool size.
	a_hw_range: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= NULL_SLOT)
		else $error("high-water count out of range");

	// A successful push advances the free list head to its successor.
	a_push_head: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && push_ok) |=> (free_head_q == $past(fn_eff)))
		else $error("free list head not advanced by push");

	// An underflow result always carries the underflow value.
	a_underflow_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_UNDERFLOW) |-> (pop_value_q == UNDERFLOW_VALUE))
		else $error("underflow result with wrong value");

endmodule

/* rtl/spms_slot_mem.sv */
module spms_slot_mem import spms_pkg::*; #(
	parameter int unsigned SLOTS  = 16,
	parameter int unsigned LINK_W = 5
) (
	input  logic                          clk,
	input  spms_mem_ctl_t                 ctl,
	input  logic [$clog2(SLOTS)-1:0]      wr_addr,
	input  logic [DATA_W-1:0]             wr_data,
	input  logic [LINK_W-1:0]             wr_link,
	input  logic [$clog2(SLOTS)-1:0]      rd_addr,
	output logic [DATA_W-1:0]             rd_data,
	output logic [LINK_W-1:0]             rd_link
);

	logic [DATA_W-1:0] data_mem [SLOTS];
	logic [LINK_W-1:0] link_mem [SLOTS];
	logic [DATA_W-1:0] rd_data_q;
	logic [LINK_W-1:0] rd_link_q;

	// Write port: a push writes value and link, a pop rewrites the link only.
	always_ff @(posedge clk) begin
		if (ctl.wr_data_en) begin
			data_mem[wr_addr] <= wr_data;
		end
		if (ctl.wr_link_en) begin
			link_mem[wr_addr] <= wr_link;
		end
	end

	// Registered read port; the word is used by the following item.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= data_mem[rd_addr];
			rd_link_q <= link_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign rd_link = rd_link_q;

endmodule
